FILE: hw/rtl/multi_substring_all_match_core_assert.svh
// assertion macros used by the checker file
`ifndef MULTI_SUBSTRING_ALL_MATCH_CORE_ASSERT_SVH
`define MULTI_SUBSTRING_ALL_MATCH_CORE_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define MSAM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MSAM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/msam_pkg.sv
// shared types, register codes and byte compare helpers
package msam_pkg;

   typedef logic [7:0] byte_type;

   // register indexes, taken from paddr[5:3]
   localparam logic [2:0] REG_NUM_PATTERNS = 3'd0;
   localparam logic [2:0] REG_IGNORE_CASE  = 3'd1;
   localparam logic [2:0] REG_PATTERN_A    = 3'd2;

   localparam byte_type NO_BYTE  = 8'h00;
   localparam byte_type WILDCARD = 8'h2E;

   // mode registers handed from the register file to the datapath
   typedef struct packed {
      logic [2:0] num_patterns;
      logic       ignore_case;
   } cfg_type;

   // fixed code page lowercase map
   function automatic byte_type fold(input byte_type c);
      byte_type r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'h20;
      end else if (c inside {8'h8A, 8'h8C, 8'h8E}) begin
         r = c + 8'h10;
      end else if (c == 8'h9F) begin
         r = 8'hFF;
      end else if (c inside {[8'hC0:8'hDE]} && c != 8'hD7) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // one window byte against one pattern byte
   function automatic logic byte_ok(input byte_type w, input byte_type p,
                                    input logic ignore_case);
      logic r;
      if (w == NO_BYTE) begin
         r = 1'b0;
      end else if (ignore_case) begin
         r = (p == WILDCARD) || (fold(w) == fold(p));
      end else begin
         r = (w == p);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/msam_csr.sv
// register file for pattern count, case mode and pattern bytes
module msam_csr #(
   parameter int MAX_PATTERNS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [5:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready,
   output msam_pkg::cfg_type    cfg,
   output logic [63:0]          patterns [MAX_PATTERNS]
);

   logic [2:0]  num_patterns_ff;
   logic        ignore_case_ff;
   logic [63:0] pattern_ff [MAX_PATTERNS];
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[5:3];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_patterns_ff <= 3'd0;
         ignore_case_ff  <= 1'b0;
         for (int i = 0; i < MAX_PATTERNS; i++) begin
            pattern_ff[i] <= 64'd0;
         end
      end else if (wr_en) begin
         if (reg_idx == msam_pkg::REG_NUM_PATTERNS) begin
            num_patterns_ff <= pwdata[2:0];
         end
         if (reg_idx == msam_pkg::REG_IGNORE_CASE) begin
            ignore_case_ff <= pwdata[0];
         end
         for (int i = 0; i < MAX_PATTERNS; i++) begin
            if (reg_idx == 3'(msam_pkg::REG_PATTERN_A + 3'(i))) begin
               pattern_ff[i] <= pwdata;
            end
         end
      end
   end

   // read back
   always_comb begin
      prdata = 64'd0;
      if (reg_idx == msam_pkg::REG_NUM_PATTERNS) begin
         prdata = {61'd0, num_patterns_ff};
      end
      if (reg_idx == msam_pkg::REG_IGNORE_CASE) begin
         prdata = {63'd0, ignore_case_ff};
      end
      for (int i = 0; i < MAX_PATTERNS; i++) begin
         if (reg_idx == 3'(msam_pkg::REG_PATTERN_A + 3'(i))) begin
            prdata = pattern_ff[i];
         end
      end
   end

   assign cfg.num_patterns = num_patterns_ff;
   assign cfg.ignore_case  = ignore_case_ff;
   assign patterns         = pattern_ff;

endmodule

FILE: hw/rtl/msam_match.sv
// compares one pattern against the byte window ending at the newest byte
module msam_match #(
   parameter int PATTERN_BYTES = 8
) (
   input  msam_pkg::byte_type window [PATTERN_BYTES],
   input  logic [63:0]        pattern,
   input  logic               ignore_case,
   output logic               hit
);

   logic [PATTERN_BYTES-1:0] nonzero;
   logic [PATTERN_BYTES-1:0] prefix;
   logic [PATTERN_BYTES-1:0] exact_len;
   logic [PATTERN_BYTES-1:0] len_match;

   // pattern length: run of nonzero bytes from the low end
   always_comb begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         nonzero[k] = (pattern[8*k +: 8] != msam_pkg::NO_BYTE);
      end
      prefix[0] = nonzero[0];
      for (int k = 1; k < PATTERN_BYTES; k++) begin
         prefix[k] = prefix[k-1] & nonzero[k];
      end
      for (int l = 1; l <= PATTERN_BYTES; l++) begin
         if (l == PATTERN_BYTES) begin
            exact_len[l-1] = prefix[l-1];
         end else begin
            exact_len[l-1] = prefix[l-1] & ~nonzero[l];
         end
      end
   end

   // one candidate alignment per length, first pattern byte on the oldest slot
   always_comb begin
      for (int l = 1; l <= PATTERN_BYTES; l++) begin
         len_match[l-1] = 1'b1;
         for (int k = 0; k < l; k++) begin
            len_match[l-1] = len_match[l-1] &
               msam_pkg::byte_ok(window[l-1-k], pattern[8*k +: 8], ignore_case);
         end
      end
   end

   // an empty pattern always counts as found
   assign hit = ~nonzero[0] | (|(exact_len & len_match));

endmodule

FILE: hw/rtl/multi_substring_all_match_core.sv
// top level: request register, window compare and result register
// Takes one text byte per cycle while req_stall is low; a request is loaded into the
// request register at the edge that takes it and is compared while it sits there, and
// the answer of a last request is loaded into the result register that drives rsp_valid
// at the edge at which it leaves the request register. All patterns
// are compared in parallel against the byte window in that single compare
// stage, which also shifts the window and collects the found flags. req_stall
// rises only when a last request waits in the request register while the
// previous answer is still held by rsp_stall. Registers sit at byte offsets
// 0, 8, 16 .. 40 and may be written only while no text is in flight.
module multi_substring_all_match_core #(
   parameter int MAX_PATTERNS  = 4,
   parameter int PATTERN_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_text_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_all_found,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int WIN_DEPTH = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;

   msam_pkg::cfg_type  cfg;
   logic [63:0]        patterns [MAX_PATTERNS];

   logic               s1_valid_ff, s1_valid_in;
   msam_pkg::byte_type s1_byte_ff;
   logic               s1_last_ff;
   msam_pkg::byte_type win_ff [WIN_DEPTH];
   msam_pkg::byte_type win_in [WIN_DEPTH];
   logic [MAX_PATTERNS-1:0] found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_all_found_ff, rsp_all_found_in;

   msam_pkg::byte_type window [PATTERN_BYTES];
   logic [MAX_PATTERNS-1:0] hits;
   logic [MAX_PATTERNS-1:0] need;
   logic [MAX_PATTERNS-1:0] found_next;
   logic [2:0]         active;
   logic               accept_req;
   logic               can_process;
   logic               fire;

   msam_csr #(.MAX_PATTERNS(MAX_PATTERNS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .patterns (patterns)
   );

   // handshake: only a last request needs the result register free
   assign can_process = ~s1_last_ff | ~rsp_valid_ff | ~rsp_stall;
   assign fire        = s1_valid_ff & can_process;
   assign req_stall   = s1_valid_ff & ~can_process;
   assign accept_req  = req_valid & ~req_stall;

   // full window, newest byte in slot zero
   assign window[0] = s1_byte_ff;
   for (genvar j = 1; j < PATTERN_BYTES; j++) begin : g_window
      assign window[j] = win_ff[j-1];
   end

   // one comparator per pattern
   for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_match
      msam_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_match (
         .window      (window),
         .pattern     (patterns[i]),
         .ignore_case (cfg.ignore_case),
         .hit         (hits[i])
      );
   end

   // active pattern mask, count clamped to the number of comparators
   always_comb begin
      if (cfg.num_patterns > 3'(MAX_PATTERNS)) begin
         active = 3'(MAX_PATTERNS);
      end else begin
         active = cfg.num_patterns;
      end
      for (int i = 0; i < MAX_PATTERNS; i++) begin
         need[i] = (3'(i) < active);
      end
   end

   assign found_next = found_ff | (hits & need);

   // next state of window, flags and result
   always_comb begin
      s1_valid_in      = s1_valid_ff;
      win_in           = win_ff;
      found_in         = found_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_all_found_in = rsp_all_found_ff;
      if (accept_req) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (fire) begin
         if (s1_last_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_all_found_in = (active != 3'd0) && ((found_next & need) == need);
            found_in         = '0;
            for (int j = 0; j < WIN_DEPTH; j++) begin
               win_in[j] = msam_pkg::NO_BYTE;
            end
         end else begin
            found_in  = found_next;
            win_in[0] = s1_byte_ff;
            for (int j = 1; j < WIN_DEPTH; j++) begin
               win_in[j] = win_ff[j-1];
            end
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= '0;
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= msam_pkg::NO_BYTE;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         win_ff       <= win_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept_req) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_text_last;
      end
      rsp_all_found_ff <= rsp_all_found_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_all_found = rsp_all_found_ff;

endmodule

FILE: hw/rtl/msam_checker.sv
// port level checks for the top level, attached by bind
`include "multi_substring_all_match_core_assert.svh"

module msam_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_text_last,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_all_found
);

   // a held result keeps its value
   `MSAM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_all_found), "result changed while stalled")

   // requests back up only behind a stalled result
   `MSAM_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled without a held result")

   // a request that is not last never produces a result
   `MSAM_ASSERT(a_no_spurious, (req_valid && !req_stall && !req_text_last) ##1 !rsp_valid |=> !rsp_valid, "result without a last request")

   // reset leaves no result pending
   `MSAM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind multi_substring_all_match_core msam_checker u_msam_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_text_last (req_text_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_all_found (rsp_all_found)
);
